FILE: rtl/core/tpsw_pkg.sv
package tpsw_pkg;

  localparam int unsigned LOG_FRAC = 30;
  localparam logic [23:0] LN2_Q24 = 24'hB17218;

  localparam logic [2:0] REG_COUNT   = 3'd0;
  localparam logic [2:0] REG_X_OFF   = 3'd1;
  localparam logic [2:0] REG_X_FROMX = 3'd2;
  localparam logic [2:0] REG_X_FROMY = 3'd3;
  localparam logic [2:0] REG_Y_OFF   = 3'd4;
  localparam logic [2:0] REG_Y_FROMX = 3'd5;
  localparam logic [2:0] REG_Y_FROMY = 3'd6;

  localparam logic signed [47:0] GAIN_ONE = 48'sh0001_0000_0000;

  typedef struct packed {
    logic               xform;
    logic               wr;
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [47:0] wx;
    logic signed [47:0] wy;
  } cmd_t;

  typedef struct packed {
    logic [6:0]         count;
    logic signed [47:0] x_off;
    logic signed [47:0] x_fx;
    logic signed [47:0] x_fy;
    logic signed [47:0] y_off;
    logic signed [47:0] y_fx;
    logic signed [47:0] y_fy;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic signed [127:0] prod;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_DIFF, BK_MUL, BK_WAIT, BK_NORM, BK_LOG, BK_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    MS_XX, MS_XY, MS_YX, MS_YY, MS_DX, MS_DY, MS_LN, MS_U, MS_WX, MS_WY
  } mul_sel_t;

  // fractional log2(1 + a/2^b) in Q0.30, bit by bit through repeated squaring
  function automatic logic [29:0] log2_frac(int unsigned a, int unsigned b);
    logic [63:0] x;
    logic [29:0] acc;
    int          k;
    x   = (64'd1 << LOG_FRAC) + (64'(a) << (LOG_FRAC - b));
    acc = '0;
    for (k = 0; k < int'(LOG_FRAC); k++) begin
      x   = (x * x) >> LOG_FRAC;
      acc = {acc[28:0], 1'b0};
      if (x >= (64'd1 << (LOG_FRAC + 1))) begin
        acc[0] = 1'b1;
        x      = x >> 1;
      end
    end
    return acc;
  endfunction

endpackage

FILE: rtl/core/thin_plate_spline_point_warp_unit.sv
// channel   direction  handshake          word
// input     in         push / full        in_operation .. in_kernel_weight_y
// result    out        empty / pop        out_mapped_x, out_mapped_y, out_clipped
// config    in         cfg_we             cfg_index, cfg_wdata
//
// A load writes the landmark table as the back end pops it. A transform runs, for each
// used landmark, six products through one shared 32x32 multiplier plus a 6-step
// leading-one search; a landmark at zero distance stops after its first two products.
// Synchronous active-low reset; the landmark table is not cleared.
// A 2-word command queue lets the input keep filling while a result waits.
module thin_plate_spline_point_warp_unit import tpsw_pkg::*; #(
  parameter int MAX_LANDMARKS       = 64,
  parameter int LOG_TABLE_ADDR_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [47:0] in_kernel_weight_x,
  input  logic signed [47:0] in_kernel_weight_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_mapped_x,
  output logic signed [31:0] out_mapped_y,
  output logic               out_clipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_valid, q_pop;
  cmd_t     q_cmd;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:   cfg_nxt.count = cfg_wdata[6:0];
        REG_X_OFF:   cfg_nxt.x_off = cfg_wdata;
        REG_X_FROMX: cfg_nxt.x_fx  = cfg_wdata;
        REG_X_FROMY: cfg_nxt.x_fy  = cfg_wdata;
        REG_Y_OFF:   cfg_nxt.y_off = cfg_wdata;
        REG_Y_FROMX: cfg_nxt.y_fx  = cfg_wdata;
        REG_Y_FROMY: cfg_nxt.y_fy  = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count <= '0;
      cfg_r.x_off <= '0;
      cfg_r.x_fx  <= GAIN_ONE;
      cfg_r.x_fy  <= '0;
      cfg_r.y_off <= '0;
      cfg_r.y_fx  <= '0;
      cfg_r.y_fy  <= GAIN_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpsw_front #(
    .MAX_LANDMARKS(MAX_LANDMARKS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_operation      (in_operation),
    .in_entry_index    (in_entry_index),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_kernel_weight_x(in_kernel_weight_x),
    .in_kernel_weight_y(in_kernel_weight_y),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop)
  );

  tpsw_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  tpsw_back #(
    .MAX_LANDMARKS      (MAX_LANDMARKS),
    .LOG_TABLE_ADDR_BITS(LOG_TABLE_ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .mreq        (mreq),
    .mrsp        (mrsp),
    .empty       (empty),
    .pop         (pop),
    .out_mapped_x(out_mapped_x),
    .out_mapped_y(out_mapped_y),
    .out_clipped (out_clipped)
  );

endmodule

FILE: rtl/core/tpsw_front.sv
module tpsw_front import tpsw_pkg::*; #(
  parameter int MAX_LANDMARKS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [47:0] in_kernel_weight_x,
  input  logic signed [47:0] in_kernel_weight_y,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  // classify: a load outside the table is dropped at the back end
  always_comb begin
    cmd_in.xform = in_operation;
    cmd_in.wr    = !in_operation && (int'(in_entry_index) < MAX_LANDMARKS);
    cmd_in.idx   = in_entry_index;
    cmd_in.x     = in_coord_x;
    cmd_in.y     = in_coord_y;
    cmd_in.wx    = in_kernel_weight_x;
    cmd_in.wy    = in_kernel_weight_y;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = fifo_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/tpsw_mul.sv
module tpsw_mul import tpsw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                busy_r;
  logic [2:0]          step_r;
  logic [63:0]         am_r, bm_r;
  logic                neg_r;
  logic [63:0]         pp_r;
  logic [1:0]          pps_r;
  logic signed [127:0] acc_r;
  logic                done_r;
  logic [31:0]         ah, bh;
  logic [127:0]        pp_sh;

  // partial products: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    ah = (step_r[1]) ? am_r[63:32] : am_r[31:0];
    bh = (step_r[0]) ? bm_r[63:32] : bm_r[31:0];
    case (pps_r)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      am_r  <= req.a[63] ? 64'(-req.a) : req.a;
      bm_r  <= req.b[63] ? 64'(-req.b) : req.b;
      neg_r <= req.a[63] ^ req.b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        pp_r  <= ah * bh;
        pps_r <= step_r[1:0];
      end
      if (step_r != 3'd0 && step_r != 3'd5) begin
        acc_r <= acc_r + signed'(pp_sh);
      end else if (step_r == 3'd5 && neg_r) begin
        acc_r <= -acc_r;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

FILE: rtl/core/tpsw_back.sv
module tpsw_back import tpsw_pkg::*; #(
  parameter int MAX_LANDMARKS       = 64,
  parameter int LOG_TABLE_ADDR_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output mul_req_t           mreq,
  input  mul_rsp_t           mrsp,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_mapped_x,
  output logic signed [31:0] out_mapped_y,
  output logic               out_clipped
);

  localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
  localparam int ROM_N = 1 << LOG_TABLE_ADDR_BITS;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [47:0] wx;
    logic signed [47:0] wy;
  } ent_t;

  logic [29:0] rom_w [ROM_N];

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    localparam logic [29:0] V = log2_frac(g, LOG_TABLE_ADDR_BITS);
    assign rom_w[g] = V;
  end

  ent_t tbl_r [MAX_LANDMARKS];
  ent_t ent_r;

  back_state_t         state_r, state_nxt;
  mul_sel_t            sel_r, sel_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, n_r, n_nxt;
  logic signed [31:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [111:0] accx_r, accx_nxt, accy_r, accy_nxt;
  logic [31:0]         dxm_r, dxm_nxt, dym_r, dym_nxt;
  logic [48:0]         d_r, d_nxt, norm_r, norm_nxt;
  logic [5:0]          sh_r, sh_nxt;
  logic [2:0]          nstep_r, nstep_nxt;
  logic signed [36:0]  l2_r, l2_nxt;
  logic signed [39:0]  lnq_r, lnq_nxt;
  logic signed [57:0]  u_r, u_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic signed [31:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic                oclip_r, oclip_nxt;

  logic                tbl_rd;
  logic signed [32:0]  dx, dy;
  logic [48:0]         dsum;
  logic [LOG_TABLE_ADDR_BITS-1:0] rom_addr;
  logic [111:0]        rx, ry;
  logic                fit_x, fit_y;

  always_comb begin
    dx       = {ent_r.lx[31], ent_r.lx} - {px_r[31], px_r};
    dy       = {ent_r.ly[31], ent_r.ly} - {py_r[31], py_r};
    dsum     = d_r + {1'b0, mrsp.prod[63:16]};
    rom_addr = norm_r[47 -: LOG_TABLE_ADDR_BITS];
    // round half up at bit 40, then check the top bits for overflow
    rx       = accx_r + (112'd1 << 39);
    ry       = accy_r + (112'd1 << 39);
    fit_x    = (&rx[111:71]) || !(|rx[111:71]);
    fit_y    = (&ry[111:71]) || !(|ry[111:71]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid && q_cmd.xform) state_nxt = BK_MUL;
      BK_READ: state_nxt = (i_r == n_r) ? BK_DONE : BK_DIFF;
      BK_DIFF: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_WAIT;
      BK_WAIT: begin
        if (mrsp.done) begin
          if (sel_r == MS_YY || sel_r == MS_WY) begin
            state_nxt = BK_READ;
          end else if (sel_r == MS_DY) begin
            state_nxt = (dsum == '0) ? BK_READ : BK_NORM;
          end else begin
            state_nxt = BK_MUL;
          end
        end
      end
      BK_NORM: if (nstep_r == 3'd5) state_nxt = BK_LOG;
      BK_LOG:  state_nxt = BK_MUL;
      BK_DONE: if (!ovalid_r) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and handshakes
  always_comb begin
    sel_nxt    = sel_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    accx_nxt   = accx_r;
    accy_nxt   = accy_r;
    dxm_nxt    = dxm_r;
    dym_nxt    = dym_r;
    d_nxt      = d_r;
    norm_nxt   = norm_r;
    sh_nxt     = sh_r;
    nstep_nxt  = nstep_r;
    l2_nxt     = l2_r;
    lnq_nxt    = lnq_r;
    u_nxt      = u_r;
    ovalid_nxt = ovalid_r && !pop;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oclip_nxt  = oclip_r;
    q_pop      = 1'b0;
    tbl_rd     = 1'b0;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;

    case (sel_r)
      MS_XX: begin
        mreq.a = {{16{cfg.x_fx[47]}}, cfg.x_fx};
        mreq.b = {{24{px_r[31]}}, px_r, 8'b0};
      end
      MS_XY: begin
        mreq.a = {{16{cfg.x_fy[47]}}, cfg.x_fy};
        mreq.b = {{24{py_r[31]}}, py_r, 8'b0};
      end
      MS_YX: begin
        mreq.a = {{16{cfg.y_fx[47]}}, cfg.y_fx};
        mreq.b = {{24{px_r[31]}}, px_r, 8'b0};
      end
      MS_YY: begin
        mreq.a = {{16{cfg.y_fy[47]}}, cfg.y_fy};
        mreq.b = {{24{py_r[31]}}, py_r, 8'b0};
      end
      MS_DX: begin
        mreq.a = {32'b0, dxm_r};
        mreq.b = {32'b0, dxm_r};
      end
      MS_DY: begin
        mreq.a = {32'b0, dym_r};
        mreq.b = {32'b0, dym_r};
      end
      MS_LN: begin
        mreq.a = {{27{l2_r[36]}}, l2_r};
        mreq.b = {40'b0, LN2_Q24};
      end
      MS_U: begin
        mreq.a = {15'b0, d_r};
        mreq.b = {{24{lnq_r[39]}}, lnq_r};
      end
      MS_WX: begin
        mreq.a = {{6{u_r[57]}}, u_r};
        mreq.b = {{16{ent_r.wx[47]}}, ent_r.wx};
      end
      MS_WY: begin
        mreq.a = {{6{u_r[57]}}, u_r};
        mreq.b = {{16{ent_r.wy[47]}}, ent_r.wy};
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.xform) begin
            px_nxt   = q_cmd.x;
            py_nxt   = q_cmd.y;
            accx_nxt = {{40{cfg.x_off[47]}}, cfg.x_off, 24'b0};
            accy_nxt = {{40{cfg.y_off[47]}}, cfg.y_off, 24'b0};
            i_nxt    = '0;
            n_nxt    = (int'(cfg.count) > MAX_LANDMARKS) ? CNT_W'(MAX_LANDMARKS)
                                                         : CNT_W'(cfg.count);
            sel_nxt  = MS_XX;
          end
        end
      end
      BK_READ: tbl_rd = (i_r != n_r);
      BK_DIFF: begin
        dxm_nxt = dx[32] ? 32'(-dx) : dx[31:0];
        dym_nxt = dy[32] ? 32'(-dy) : dy[31:0];
        sel_nxt = MS_DX;
      end
      BK_MUL: mreq.start = 1'b1;
      BK_WAIT: begin
        if (mrsp.done) begin
          case (sel_r)
            MS_XX: begin
              accx_nxt = accx_r + mrsp.prod[111:0];
              sel_nxt  = MS_XY;
            end
            MS_XY: begin
              accx_nxt = accx_r + mrsp.prod[111:0];
              sel_nxt  = MS_YX;
            end
            MS_YX: begin
              accy_nxt = accy_r + mrsp.prod[111:0];
              sel_nxt  = MS_YY;
            end
            MS_YY: accy_nxt = accy_r + mrsp.prod[111:0];
            MS_DX: begin
              d_nxt   = {1'b0, mrsp.prod[63:16]};
              sel_nxt = MS_DY;
            end
            MS_DY: begin
              d_nxt     = dsum;
              norm_nxt  = dsum;
              sh_nxt    = '0;
              nstep_nxt = '0;
              // zero distance adds nothing: skip to the next landmark
              if (dsum == '0) i_nxt = CNT_W'(i_r + 1'b1);
            end
            MS_LN: begin
              lnq_nxt = mrsp.prod[63:24];
              sel_nxt = MS_U;
            end
            MS_U: begin
              u_nxt   = mrsp.prod[87:30];
              sel_nxt = MS_WX;
            end
            MS_WX: begin
              accx_nxt = accx_r + mrsp.prod[111:0];
              sel_nxt  = MS_WY;
            end
            MS_WY: begin
              accy_nxt = accy_r + mrsp.prod[111:0];
              i_nxt    = CNT_W'(i_r + 1'b1);
            end
            default: sel_nxt = sel_r;
          endcase
        end
      end
      BK_NORM: begin
        nstep_nxt = nstep_r + 3'd1;
        case (nstep_r)
          3'd0: if (norm_r[48:17] == '0) begin
            norm_nxt = norm_r << 32;
            sh_nxt   = sh_r + 6'd32;
          end
          3'd1: if (norm_r[48:33] == '0) begin
            norm_nxt = norm_r << 16;
            sh_nxt   = sh_r + 6'd16;
          end
          3'd2: if (norm_r[48:41] == '0) begin
            norm_nxt = norm_r << 8;
            sh_nxt   = sh_r + 6'd8;
          end
          3'd3: if (norm_r[48:45] == '0) begin
            norm_nxt = norm_r << 4;
            sh_nxt   = sh_r + 6'd4;
          end
          3'd4: if (norm_r[48:47] == '0) begin
            norm_nxt = norm_r << 2;
            sh_nxt   = sh_r + 6'd2;
          end
          3'd5: if (!norm_r[48]) begin
            norm_nxt = norm_r << 1;
            sh_nxt   = sh_r + 6'd1;
          end
          default: norm_nxt = norm_r;
        endcase
      end
      BK_LOG: begin
        // integer part is (lead - 16) = 32 - shift
        l2_nxt  = $signed({7'(7'd32 - {1'b0, sh_r}), rom_w[rom_addr]});
        sel_nxt = MS_LN;
      end
      BK_DONE: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = fit_x ? rx[71:40] : (rx[111] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
          oy_nxt     = fit_y ? ry[71:40] : (ry[111] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
          oclip_nxt  = !fit_x || !fit_y;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      sel_r    <= MS_XX;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sel_r    <= sel_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    dxm_r   <= dxm_nxt;
    dym_r   <= dym_nxt;
    d_r     <= d_nxt;
    norm_r  <= norm_nxt;
    sh_r    <= sh_nxt;
    nstep_r <= nstep_nxt;
    l2_r    <= l2_nxt;
    lnq_r   <= lnq_nxt;
    u_r     <= u_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oclip_r <= oclip_nxt;
  end

  // landmark table: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid && q_cmd.wr) begin
      tbl_r[IDX_W'(q_cmd.idx)] <= {q_cmd.x, q_cmd.y, q_cmd.wx, q_cmd.wy};
    end
    if (tbl_rd) begin
      ent_r <= tbl_r[i_r[IDX_W-1:0]];
    end
  end

  assign empty        = !ovalid_r;
  assign out_mapped_x = ox_r;
  assign out_mapped_y = oy_r;
  assign out_clipped  = oclip_r;

endmodule

FILE: rtl/core/tpsw_checker.sv
module tpsw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_mapped_x,
  input logic signed [31:0] out_mapped_y,
  input logic               out_clipped
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_mapped_x) && $stable(out_mapped_y)
                       && $stable(out_clipped))
    else $error("stalled result word changed");

  a_drain_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty) && $past(rst_n) |-> $past(pop))
    else $error("result word dropped without pop");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_clipped |-> out_mapped_x == 32'sh7FFF_FFFF
      || out_mapped_x == 32'sh8000_0000 || out_mapped_y == 32'sh7FFF_FFFF
      || out_mapped_y == 32'sh8000_0000)
    else $error("clip flag without a saturated value");

endmodule

bind thin_plate_spline_point_warp_unit tpsw_checker u_chk (.*);
